@@ hdl/sdfh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sdfh_pkg;

    localparam int NUM_BINS_DEF = 1024;

    localparam int CFG_W      = 31;
    localparam int BINCNT_W   = 11;
    localparam int WORD_W     = 32;
    localparam int RDBIN_W    = 10;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;

    localparam logic [WORD_W-1:0] ITER_MAX     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MARKER_COORD = 32'hFFFF_FF9C;
    localparam logic [WORD_W-1:0] ITER_NONE    = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

    localparam logic [BINCNT_W-1:0] BIN_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_PASSED  = 2'd1,
        ST_BACKUP  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_START_ITER = 2'd0,
        REG_END_ITER   = 2'd1,
        REG_BIN_COUNT  = 2'd2
    } cfg_index_t;

    localparam logic KIND_STREAM = 1'b0;
    localparam logic KIND_READ   = 1'b1;

endpackage

`default_nettype wire

@@ hdl/sdfh_bin_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sdfh_bin_store #(
    parameter int NUM_BINS = 1024,
    parameter int ADDR_W   = 10,
    parameter int DATA_W   = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   ready
);

    logic [DATA_W-1:0] mem [NUM_BINS];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(NUM_BINS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign mem_we    = clr_busy_reg || wr_en;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

endmodule

`default_nettype wire

@@ hdl/sparse_draw_frequency_histogram_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sparse draw frequency histogram.
// Input stream (s_axis_*): each request is either a sampler word (tuser = 0)
// or a bin read (tuser = 1). Negative words are iteration markers, others are
// coordinates; coordinates in the selected iteration window and below the
// bin limit bump a saturating 32-bit bin counter.
// Output stream (m_axis_*): exactly one result request per input request,
// in order: bin count, current iteration, counted flag and run status.
// Throughput: one request per cycle while m_axis_tready is high, including
// repeated hits on the same bin (the read-modify-write of the bin RAM is
// forwarded). Pipeline: the RAM stage holds the registered RAM read, then
// the increment feeds the output register that drives m_axis_tvalid.
// Reset: parser state returns to "no iteration"; then the bin RAM is swept to
// zero, one entry per cycle, over all NUM_BINS entries with s_axis_tready low.
// Config writes (cfg_we) are taken at any time, including during the sweep.
// Stall: if m_axis_tready is low, one result waits in the output register,
// one more in the RAM stage, and then s_axis_tready drops.
module sparse_draw_frequency_histogram_core #(
    parameter int NUM_BINS = sdfh_pkg::NUM_BINS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_addr,
    input  wire logic [sdfh_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // stream_word[31:0], read_bin[41:32], zero[47:42]
    input  wire logic [sdfh_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[0]
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // count_value[31:0], current_iteration[63:32], counted[64],
    // run_status[66:65], zero[71:67]
    output logic [sdfh_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    import sdfh_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [CFG_W-1:0]    start_iter_reg;
    logic [CFG_W-1:0]    end_iter_reg;
    logic [BINCNT_W-1:0] bin_count_reg;

    logic [WORD_W-1:0]   iter_reg;
    logic [WORD_W-1:0]   iter_next;
    logic [WORD_W-1:0]   prev_reg;
    logic [WORD_W-1:0]   prev_next;
    status_t             status_reg;
    status_t             status_next;

    logic                s1_valid_reg;
    logic                s1_rd_reg;
    logic                s1_cnt_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [WORD_W-1:0]   s1_iter_reg;
    status_t             s1_status_reg;
    logic                s1_fwd_reg;
    logic [WORD_W-1:0]   s1_fwd_data_reg;

    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                store_ready;
    logic [WORD_W-1:0]   store_rd_data;

    logic                accept;
    logic                s1_adv;
    logic                kind;
    logic [WORD_W-1:0]   word;
    logic [RDBIN_W-1:0]  read_bin;
    logic                active;
    logic                marker;
    logic [WORD_W-1:0]   mk_iter;
    logic                mk_err;
    logic                implicit_new;
    logic [WORD_W-1:0]   iter_inc;
    logic [WORD_W-1:0]   cnt_iter;
    logic                in_window;
    logic                coord_ok;
    logic                cnt_now;
    logic                rd_ok;
    logic [AW-1:0]       req_addr;

    logic [WORD_W-1:0]   s1_old;
    logic [WORD_W-1:0]   s1_new;
    logic [WORD_W-1:0]   s1_value;

    assign kind     = s_axis_tuser;
    assign word     = s_axis_tdata[WORD_W-1:0];
    assign read_bin = s_axis_tdata[WORD_W+RDBIN_W-1:WORD_W];

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = store_ready && (!s1_valid_reg || s1_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // parser
    assign active       = (kind == KIND_STREAM) && (status_reg == ST_RUNNING);
    assign marker       = word[WORD_W-1];
    assign mk_iter      = ~word;
    assign mk_err       = !iter_reg[WORD_W-1] && (iter_reg != '0)
                          && ($signed(mk_iter) <= $signed(iter_reg));
    assign implicit_new = !marker && ($signed(word) < $signed(prev_reg));
    assign iter_inc     = iter_reg + 1'b1;
    assign cnt_iter     = implicit_new ? iter_inc : iter_reg;
    assign in_window    = !cnt_iter[WORD_W-1]
                          && (cnt_iter[CFG_W-1:0] >= start_iter_reg)
                          && (cnt_iter[CFG_W-1:0] <= end_iter_reg);
    assign coord_ok     = (word < WORD_W'(bin_count_reg)) && (word < WORD_W'(NUM_BINS));
    assign rd_ok        = (WORD_W'(read_bin) < WORD_W'(NUM_BINS));
    assign req_addr     = (kind == KIND_READ) ? AW'(read_bin) : AW'(word);

    always_comb
    begin
        iter_next   = iter_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        cnt_now     = 1'b0;
        if (active)
        begin
            if (marker)
            begin
                if (mk_err)
                begin
                    status_next = ST_BACKUP;
                end
                else
                begin
                    iter_next = mk_iter;
                    prev_next = MARKER_COORD;
                    if (mk_iter[CFG_W-1:0] > end_iter_reg)
                    begin
                        status_next = ST_PASSED;
                    end
                end
            end
            else if (implicit_new)
            begin
                prev_next = word;
                if (iter_reg == ITER_MAX)
                begin
                    status_next = ST_PASSED;
                end
                else
                begin
                    iter_next = iter_inc;
                    if (iter_inc[CFG_W-1:0] > end_iter_reg)
                    begin
                        status_next = ST_PASSED;
                    end
                    else
                    begin
                        cnt_now = in_window && coord_ok;
                    end
                end
            end
            else
            begin
                prev_next = word;
                cnt_now   = in_window && coord_ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_iter_reg <= '0;
            end_iter_reg   <= ITER_MAX[CFG_W-1:0];
            bin_count_reg  <= BIN_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_START_ITER: start_iter_reg <= cfg_data;
                REG_END_ITER:   end_iter_reg   <= cfg_data;
                REG_BIN_COUNT:  bin_count_reg  <= cfg_data[BINCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg   <= ITER_NONE;
            prev_reg   <= ITER_NONE;
            status_reg <= ST_RUNNING;
        end
        else if (accept)
        begin
            iter_reg   <= iter_next;
            prev_reg   <= prev_next;
            status_reg <= status_next;
        end
    end

    // RAM stage
    assign s1_old   = s1_fwd_reg ? s1_fwd_data_reg : store_rd_data;
    assign s1_new   = (s1_old == COUNT_MAX) ? s1_old : s1_old + 1'b1;
    assign s1_value = s1_cnt_reg ? s1_new : (s1_rd_reg ? s1_old : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg       <= (kind == KIND_READ) && rd_ok;
            s1_cnt_reg      <= cnt_now;
            s1_addr_reg     <= req_addr;
            s1_iter_reg     <= iter_next;
            s1_status_reg   <= status_next;
            s1_fwd_reg      <= s1_adv && s1_cnt_reg && (s1_addr_reg == req_addr);
            s1_fwd_data_reg <= s1_new;
        end
    end

    sdfh_bin_store #(
        .NUM_BINS (NUM_BINS),
        .ADDR_W   (AW),
        .DATA_W   (WORD_W)
    ) u_bin_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req_addr),
        .rd_data (store_rd_data),
        .wr_en   (s1_adv && s1_cnt_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_new),
        .ready   (store_ready)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= {5'b0, s1_status_reg, s1_cnt_reg, s1_iter_reg, s1_value};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import sdfh_pkg::*;

    localparam int     NBINS       = NUM_BINS_DEF;
    localparam int     HIDX_W      = $clog2(NBINS);
    localparam longint ITER_TOP    = 64'sd2147483647;
    localparam int     GAP_MAX     = 19;
    localparam int     HOLD_CYCLES = 300;
    localparam int     PAD_W       = IN_DATA_W - WORD_W - RDBIN_W;

    typedef struct {
        logic               kind;
        logic [WORD_W-1:0]  word;
        logic [RDBIN_W-1:0] rbin;
        int                 gap;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              counted;
        logic [WORD_W-1:0] iter;
        logic [WORD_W-1:0] count;
    } bin_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [1:0]            cfg_addr      = '0;
    logic [CFG_W-1:0]      cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // histogram shadow
    logic [WORD_W-1:0] hist [NBINS];
    longint            iter_now   = -1;
    longint            prev_coord = -1;
    status_t           run_st     = ST_RUNNING;
    longint            cfg_first  = 0;
    longint            cfg_last   = ITER_TOP;
    int                cfg_bins   = 1024;

    req_t        sample_q[$];
    bin_result_t count_exp_q[$];
    req_t        staged_req;
    logic        staged      = 1'b0;
    logic        tx_idle     = 1'b1;
    logic        rx_idle     = 1'b1;
    logic        rx_hold     = 1'b0;
    logic        pressure_go = 1'b0;
    int          rx_wait     = 0;
    int          rx_count    = 0;
    int          err_cnt     = 0;

    sparse_draw_frequency_histogram_core #(
        .NUM_BINS(NBINS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic tally(input longint c, output logic [WORD_W-1:0] val);
        int lim;
        val = '0;
        lim = (cfg_bins < NBINS) ? cfg_bins : NBINS;
        if (iter_now < cfg_first || iter_now > cfg_last || c >= lim)
            return 1'b0;
        if (hist[c[HIDX_W-1:0]] != COUNT_MAX)
            hist[c[HIDX_W-1:0]] = hist[c[HIDX_W-1:0]] + 1;
        val = hist[c[HIDX_W-1:0]];
        return 1'b1;
    endfunction

    function automatic bin_result_t histogram_step(input req_t r);
        bin_result_t       res;
        longint            w;
        longint            nxt;
        logic [WORD_W-1:0] cval;
        res  = '0;
        cval = '0;
        w    = longint'(signed'(r.word));
        if (r.kind == KIND_READ)
            cval = hist[r.rbin];
        else if (run_st == ST_RUNNING)
        begin
            if (w < 0)
            begin
                nxt = -w - 1;
                // iteration 0 or none never backs up
                if (iter_now > 0 && nxt <= iter_now)
                    run_st = ST_BACKUP;
                else
                begin
                    iter_now   = nxt;
                    prev_coord = longint'(signed'(MARKER_COORD));
                    if (nxt > cfg_last)
                        run_st = ST_PASSED;
                end
            end
            else if (w < prev_coord)
            begin
                prev_coord = w;
                if (iter_now >= ITER_TOP)
                    run_st = ST_PASSED;
                else
                begin
                    iter_now++;
                    if (iter_now > cfg_last)
                        run_st = ST_PASSED;
                    else
                        res.counted = tally(w, cval);
                end
            end
            else
            begin
                res.counted = tally(w, cval);
                prev_coord  = w;
            end
        end
        res.count  = cval;
        res.iter   = iter_now[WORD_W-1:0];
        res.status = run_st;
        return res;
    endfunction

    function automatic req_t mk(input logic kind, input logic [WORD_W-1:0] word,
                                input int rbin);
        req_t r;
        r.kind = kind;
        r.word = word;
        r.rbin = rbin[RDBIN_W-1:0];
        r.gap  = 0;
        return r;
    endfunction

    function automatic req_t draw_item();
        req_t   r;
        int     pick;
        int     lim;
        longint nxt;
        lim    = (cfg_bins < NBINS) ? cfg_bins : NBINS;
        r.kind = KIND_STREAM;
        r.word = $urandom();
        r.rbin = RDBIN_W'($urandom_range(0, NBINS - 1));
        r.gap  = 0;
        pick   = $urandom_range(0, 99);
        if (pick < 15)
            r.kind = KIND_READ;
        else if (pick < 20)
        begin
            nxt    = iter_now + 1 + $urandom_range(0, 3);
            r.word = 32'(-(nxt + 1));
        end
        else if (pick < 30)
            r.word = $urandom() & 32'h7FFF_FFFF;
        else if (pick < 50 && prev_coord >= 0)
            r.word = prev_coord[WORD_W-1:0];
        else
            r.word = $urandom_range(0, lim + 8);
        return r;
    endfunction

    task automatic queue_req(input req_t r);
        r.gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        count_exp_q.push_back(histogram_step(r));
        sample_q.push_back(r);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_ITER: cfg_first = longint'(val);
            REG_END_ITER:   cfg_last  = longint'(val);
            default:        cfg_bins  = int'(val[BINCNT_W-1:0]);
        endcase
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || staged || count_exp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("tb: mismatch: %s", msg);
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] data);
        bin_result_t got;
        bin_result_t want;
        got.count   = data[31:0];
        got.iter    = data[63:32];
        got.counted = data[64];
        got.status  = data[66:65];
        rx_count++;
        if (count_exp_q.size() == 0)
        begin
            note_error($sformatf("result %0d with nothing pending: %h", rx_count, data));
            return;
        end
        want = count_exp_q.pop_front();
        if (got.count !== want.count || got.iter !== want.iter
            || got.counted !== want.counted || got.status !== want.status)
            note_error($sformatf(
                "result %0d exp count %h iter %h counted %b status %0d, got %h %h %b %0d",
                rx_count, want.count, want.iter, want.counted, want.status,
                got.count, got.iter, got.counted, got.status));
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (!staged && sample_q.size() != 0)
            begin
                staged_req = sample_q.pop_front();
                staged     = 1'b1;
            end
            if (staged && staged_req.gap == 0)
            begin
                staged = 1'b0;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= staged_req.kind;
                s_axis_tdata  <= {{PAD_W{1'b0}}, staged_req.rbin, staged_req.word};
            end
            else
            begin
                if (staged)
                    staged_req.gap--;
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(m_axis_tdata);
                rx_wait = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (rx_wait != 0)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // long receiver stall so the input side backs up
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int choice;
        foreach (hist[i])
            hist[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, no iteration yet
        queue_req(mk(KIND_READ, 32'h0, NBINS - 1));
        queue_req(mk(KIND_READ, 32'hFFFF_FFFF, 0));
        queue_req(mk(KIND_STREAM, 32'd7, 0));
        queue_req(mk(KIND_STREAM, 32'd9, 0));
        wait_idle();

        // iteration 0 only; any drop here would pass end_iter
        write_reg(REG_END_ITER, '0);
        queue_req(mk(KIND_STREAM, 32'hFFFF_FFFF, 0));
        queue_req(mk(KIND_STREAM, 32'd0, 0));
        queue_req(mk(KIND_STREAM, 32'd0, 0));
        queue_req(mk(KIND_STREAM, 32'hFFFF_FFFF, 0));
        queue_req(mk(KIND_STREAM, 32'd5, 0));
        queue_req(mk(KIND_STREAM, 32'd1023, 0));
        queue_req(mk(KIND_STREAM, 32'd1024, 0));
        queue_req(mk(KIND_STREAM, 32'h7FFF_FFFF, 0));
        queue_req(mk(KIND_READ, 32'h0, 0));
        queue_req(mk(KIND_READ, 32'h0, 5));
        queue_req(mk(KIND_READ, 32'h0, 1023));
        wait_idle();

        write_reg(REG_END_ITER, 31'h7FFF_FFFF);
        write_reg(REG_BIN_COUNT, 31'd3);
        queue_req(mk(KIND_STREAM, 32'd2, 0));
        queue_req(mk(KIND_STREAM, 32'd3, 0));
        queue_req(mk(KIND_STREAM, 32'd2, 0));
        queue_req(mk(KIND_STREAM, 32'hFFFF_FFFB, 0));
        queue_req(mk(KIND_STREAM, 32'd0, 0));
        queue_req(mk(KIND_READ, 32'h0, 2));

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            case (ph)
                0:
                begin
                    write_reg(REG_START_ITER, '0);
                    write_reg(REG_BIN_COUNT, 31'd1024);
                end
                1: write_reg(REG_BIN_COUNT, '0);
                2:
                begin
                    write_reg(REG_START_ITER, 31'(iter_now + 10));
                    write_reg(REG_BIN_COUNT, 31'd2047);
                end
                3:
                begin
                    // window empty: start above end
                    write_reg(REG_START_ITER, 31'h7FFF_FFFF);
                    write_reg(REG_END_ITER, 31'h7FFF_FFFE);
                    write_reg(REG_BIN_COUNT, 31'd16);
                end
                4:
                begin
                    write_reg(REG_START_ITER, '0);
                    write_reg(REG_END_ITER, 31'(iter_now + 500000));
                    write_reg(REG_BIN_COUNT, 31'd1);
                end
                5:
                begin
                    write_reg(REG_END_ITER, 31'h7FFF_FFFF);
                    write_reg(REG_BIN_COUNT, 31'd8);
                    tx_idle     = 1'b0;
                    pressure_go = 1'b1;
                end
                6:
                begin
                    write_reg(REG_START_ITER, 31'(iter_now));
                    write_reg(REG_BIN_COUNT, 31'd64);
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                default:
                begin
                    write_reg(REG_START_ITER, 31'(iter_now + 2 - $urandom_range(0, 4)));
                    write_reg(REG_BIN_COUNT, 31'($urandom_range(1, 1024)));
                end
            endcase
            repeat (150) queue_req(draw_item());
        end

        // the run can stop only once: pick how it ends
        wait_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_reg(REG_START_ITER, '0);
        choice = $urandom_range(0, 2);
        if (choice == 0)
        begin
            write_reg(REG_END_ITER, 31'(iter_now + 2));
            queue_req(mk(KIND_STREAM, 32'd5, 0));
            queue_req(mk(KIND_STREAM, 32'd2, 0));
            queue_req(mk(KIND_STREAM, 32'd6, 0));
            queue_req(mk(KIND_STREAM, 32'd1, 0));
            queue_req(mk(KIND_STREAM, 32'd0, 0));
        end
        else
        begin
            write_reg(REG_END_ITER, 31'h7FFF_FFFF);
            queue_req(mk(KIND_STREAM, 32'h8000_0000, 0));
            queue_req(mk(KIND_STREAM, 32'd5, 0));
            if (choice == 1)
                queue_req(mk(KIND_STREAM, 32'd1, 0));
            else
                queue_req(mk(KIND_STREAM, 32'hFFFF_FFFF, 0));
        end
        repeat (40) queue_req(draw_item());
        wait_idle();

        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
